### sv/interval_tag_table_assert.svh
// assertion macros for the interval tag table
`ifndef INTERVAL_TAG_TABLE_ASSERT_SVH
`define INTERVAL_TAG_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define ITT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("interval tag table assertion failed");
`define ITT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("interval tag table assertion failed");
`else
`define ITT_ASSERT(lbl, prop)
`define ITT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### sv/itt_pkg.sv
// types and codes for the interval tag table
package itt_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_FIND   = 3'd2,
		CMD_INNER  = 3'd3,
		CMD_OUTER  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_INS,
		S_PUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] first;
		logic [15:0] last;
	} entry_t;

	localparam int IN_W  = 88;
	localparam int OUT_W = 72;

endpackage

### sv/interval_tag_table.sv
// interval tag table: sorted interval store with id lookup and stabbing queries
//
// One command word enters on the s_ side, one result word leaves on the m_ side.
// Commands: insert, remove by id, find by id, innermost and outermost query.
// The table lives in a single-port-write, single-port-read memory of MAX_TAGS
// entries, and one compare unit walks it one entry per cycle under a small
// sequencer; s_tready is low while a command is at work.
// Find, remove and both queries walk the table from entry 0 upward; remove
// shifts the tail down during the same walk. Insert walks down from the top
// and shifts entries up until its slot is found. A full insert, an unknown
// command or a command on an empty table goes straight to the result.
// The memory read port limits the walk to one entry per cycle.
// The result sits in an output register; the next command is accepted while it
// waits, but its own result is held back until the receiver takes the last one.
// Reset empties the table (count to zero) and drops any pending result; memory
// contents are not cleared and are never read before being written.
module interval_tag_table import itt_pkg::*; #(
	parameter int MAX_TAGS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// cmd, tag_id, first_frame, last_frame, query_frame
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status, hit_id, hit_first, hit_last, entry_count
	output logic [OUT_W-1:0] m_tdata
);

	localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
	localparam int CW = $clog2(MAX_TAGS + 1);

	entry_t mem [MAX_TAGS];

	state_t         state_q, state_d;
	cmd_t           cmd_q;
	entry_t         new_ent;
	logic [15:0]    frame_q;
	logic [CW-1:0]  count_q, count_d;
	logic [AW-1:0]  rd_addr_q, rd_addr_d;
	logic           rd_done_q, rd_done_d;
	logic [AW-1:0]  addr_s1;
	logic           vld_s1;
	entry_t         rdata_s1;
	logic           hit_q, hit_d;
	logic           full_q, full_d;
	entry_t         ent_q, ent_d;
	logic [15:0]    span_q, span_d;

	logic           accept;
	cmd_t           in_cmd;
	entry_t         in_ent;
	logic [15:0]    in_frame;
	logic [AW-1:0]  last_idx;
	logic           issue;
	logic           we;
	logic [AW-1:0]  waddr;
	entry_t         wdata;
	logic           load_out;
	logic           id_match;
	logic           contain;
	logic [15:0]    span;
	logic           better;

	logic           m_tvalid_q;
	status_t        m_sts_q;
	entry_t         m_ent_q;
	logic [4:0]     m_count_q;
	status_t        out_sts;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_cmd   = cmd_t'(s_tdata[2:0]);
	assign in_ent   = '{id: s_tdata[34:3], first: s_tdata[50:35], last: s_tdata[66:51]};
	assign in_frame = s_tdata[82:67];
	assign last_idx = AW'(count_q - 1'b1);

	assign id_match = (rdata_s1.id == new_ent.id);
	assign contain  = (frame_q >= rdata_s1.first) && (frame_q <= rdata_s1.last);
	assign span     = rdata_s1.last - rdata_s1.first;
	assign better   = (cmd_q == CMD_INNER) ? (span < span_q) : (span > span_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_done_q <= 1'b0;
			vld_s1    <= 1'b0;
			hit_q     <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rd_done_q <= rd_done_d;
			vld_s1    <= issue;
			hit_q     <= hit_d;
			full_q    <= full_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= in_cmd;
			new_ent <= in_ent;
			frame_q <= in_frame;
		end
		rd_addr_q <= rd_addr_d;
		addr_s1   <= rd_addr_q;
		ent_q     <= ent_d;
		span_q    <= span_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_addr_q];
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rd_addr_d = rd_addr_q;
		rd_done_d = rd_done_q;
		hit_d     = hit_q;
		full_d    = full_q;
		ent_d     = ent_q;
		span_d    = span_q;
		issue     = 1'b0;
		we        = 1'b0;
		waddr     = '0;
		wdata     = new_ent;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					hit_d     = 1'b0;
					full_d    = 1'b0;
					rd_done_d = 1'b0;
					case (in_cmd) inside
						CMD_INSERT: begin
							if (count_q == CW'(MAX_TAGS)) begin
								full_d  = 1'b1;
								state_d = S_DONE;
							end else if (count_q == '0) begin
								we      = 1'b1;
								wdata   = in_ent;
								hit_d   = 1'b1;
								ent_d   = in_ent;
								count_d = CW'(count_q + 1'b1);
								state_d = S_DONE;
							end else begin
								rd_addr_d = last_idx;
								state_d   = S_INS;
							end
						end
						CMD_REMOVE, CMD_FIND, CMD_INNER, CMD_OUTER: begin
							rd_addr_d = '0;
							state_d   = (count_q == '0) ? S_DONE : S_SCAN;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (!rd_done_q) begin
					issue     = 1'b1;
					rd_addr_d = AW'(rd_addr_q + 1'b1);
					rd_done_d = (rd_addr_q == last_idx);
				end
				if (vld_s1) begin
					case (cmd_q) inside
						CMD_FIND: begin
							if (!hit_q && id_match) begin
								hit_d = 1'b1;
								ent_d = rdata_s1;
							end
						end
						CMD_REMOVE: begin
							if (!hit_q) begin
								if (id_match) begin
									hit_d = 1'b1;
									ent_d = rdata_s1;
								end
							end else begin
								we    = 1'b1;
								waddr = AW'(addr_s1 - 1'b1);
								wdata = rdata_s1;
							end
						end
						default: begin
							if (contain && (!hit_q || better)) begin
								hit_d  = 1'b1;
								ent_d  = rdata_s1;
								span_d = span;
							end
						end
					endcase
					if (addr_s1 == last_idx) begin
						state_d = S_DONE;
						if (cmd_q == CMD_REMOVE && (hit_q || id_match)) begin
							count_d = CW'(count_q - 1'b1);
						end
					end
				end
			end
			S_INS: begin
				if (!rd_done_q) begin
					issue     = 1'b1;
					rd_addr_d = AW'(rd_addr_q - 1'b1);
					rd_done_d = (rd_addr_q == '0);
				end
				if (vld_s1) begin
					we    = 1'b1;
					waddr = AW'(addr_s1 + 1'b1);
					if (rdata_s1.first > new_ent.first) begin
						wdata = rdata_s1;
						if (addr_s1 == '0) begin
							state_d = S_PUT;
						end
					end else begin
						hit_d   = 1'b1;
						ent_d   = new_ent;
						count_d = CW'(count_q + 1'b1);
						state_d = S_DONE;
					end
				end
			end
			S_PUT: begin
				we      = 1'b1;
				hit_d   = 1'b1;
				ent_d   = new_ent;
				count_d = CW'(count_q + 1'b1);
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_sts = full_q ? STS_FULL : (hit_q ? STS_OK : STS_NOT_FOUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_sts_q   <= out_sts;
			m_ent_q   <= hit_q ? ent_q : '0;
			m_count_q <= 5'(count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_count_q, m_ent_q.last, m_ent_q.first, m_ent_q.id, m_sts_q};

`include "interval_tag_table_assert.svh"

	`ITT_ASSERT_ALWAYS(a_count_max, !arst_n || (count_q <= CW'(MAX_TAGS)))
	`ITT_ASSERT(a_count_step, (count_q != $past(count_q)) |->
		((count_q == CW'($past(count_q) + 1'b1)) || (count_q == CW'($past(count_q) - 1'b1))))
	`ITT_ASSERT(a_write_in_range, we |-> (CW'(waddr) <= count_q))
	`ITT_ASSERT(a_full_count, (m_tvalid_q && m_sts_q == STS_FULL) |-> (m_count_q == 5'(MAX_TAGS)))

endmodule
